[design/vpimt_pkg.sv]
`timescale 1ns / 1ps

package vpimt_pkg;

    localparam int MASS_W = 22;
    localparam int CODE_W = 32;
    localparam int MOM_W = 31;
    localparam int MAG_W = 31;
    localparam int SUM_MAG_W = 32;
    localparam int TAG_W = 3;
    localparam int CFG_ADDR_W = 2;
    localparam int WIDE_W = 64;
    localparam int ROOT_W = 32;
    localparam int SQRT_STEPS = 32;
    localparam int FIFO_DEPTH = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_ELECTRON_MASS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PION_MASS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PROTON_MASS = 2'd2;

    localparam logic [MASS_W-1:0] ELECTRON_MASS_RESET = 22'd511;
    localparam logic [MASS_W-1:0] PION_MASS_RESET = 22'd139570;
    localparam logic [MASS_W-1:0] PROTON_MASS_RESET = 22'd938272;

    localparam logic [CODE_W-1:0] CODE_ELECTRON = 32'd11;
    localparam logic [CODE_W-1:0] CODE_PION = 32'd211;
    localparam logic [CODE_W-1:0] CODE_PROTON = 32'd2212;

    localparam logic [TAG_W-1:0] TAG_NONE = 3'd0;
    localparam logic [TAG_W-1:0] TAG_PHOTON = 3'd1;
    localparam logic [TAG_W-1:0] TAG_KSHORT = 3'd2;
    localparam logic [TAG_W-1:0] TAG_LAMBDA = 3'd3;
    localparam logic [TAG_W-1:0] TAG_ANTILAMBDA = 3'd4;

    // One classified track pair as it waits between front and back.
    typedef struct packed {
        logic                             hyp;
        logic [TAG_W-1:0]                 tag;
        logic [MASS_W-1:0]                m1;
        logic [MASS_W-1:0]                m2;
        logic [2:0][MAG_W-1:0]            mag1;
        logic [2:0][MAG_W-1:0]            mag2;
        logic [2:0][SUM_MAG_W-1:0]        msum;
    } entry_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [ROOT_W-1:0]  mass;
        logic               ok;
    } result_t;

endpackage

[design/v0_pair_invariant_mass_tagger_core.sv]
// Throughput: one transaction per cycle; the back pipeline never stalls, so busy stays low.
// Most of the latency comes from the two 32-stage square root pipelines in series.
// Reset (rst_n, asynchronous, active low) clears all valid state and loads the
// mass registers with 511, 139570 and 938272 keV; the receiver cannot stall results.
`timescale 1ns / 1ps

module v0_pair_invariant_mass_tagger_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [vpimt_pkg::CODE_W-1:0]     first_code,
    input  logic signed [vpimt_pkg::CODE_W-1:0]     second_code,
    input  logic signed [vpimt_pkg::MOM_W-1:0]      first_px,
    input  logic signed [vpimt_pkg::MOM_W-1:0]      first_py,
    input  logic signed [vpimt_pkg::MOM_W-1:0]      first_pz,
    input  logic signed [vpimt_pkg::MOM_W-1:0]      second_px,
    input  logic signed [vpimt_pkg::MOM_W-1:0]      second_py,
    input  logic signed [vpimt_pkg::MOM_W-1:0]      second_pz,
    input  logic                                    cfg_wr_en,
    input  logic [vpimt_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [vpimt_pkg::MASS_W-1:0]            cfg_wdata,
    output logic                                    done,
    output logic [vpimt_pkg::TAG_W-1:0]             tag,
    output logic [vpimt_pkg::ROOT_W-1:0]            pair_mass_kev,
    output logic                                    mass_valid
);

    // Mass hypothesis registers. An index beyond the list is ignored.
    logic [vpimt_pkg::MASS_W-1:0] electron_mass_reg;
    logic [vpimt_pkg::MASS_W-1:0] pion_mass_reg;
    logic [vpimt_pkg::MASS_W-1:0] proton_mass_reg;

    logic               fifo_full, fifo_empty, push;
    vpimt_pkg::entry_t  push_entry, head;
    vpimt_pkg::result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            electron_mass_reg <= vpimt_pkg::ELECTRON_MASS_RESET;
            pion_mass_reg <= vpimt_pkg::PION_MASS_RESET;
            proton_mass_reg <= vpimt_pkg::PROTON_MASS_RESET;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_addr == vpimt_pkg::REG_ELECTRON_MASS)
            begin
                electron_mass_reg <= cfg_wdata;
            end
            if (cfg_addr == vpimt_pkg::REG_PION_MASS)
            begin
                pion_mass_reg <= cfg_wdata;
            end
            if (cfg_addr == vpimt_pkg::REG_PROTON_MASS)
            begin
                proton_mass_reg <= cfg_wdata;
            end
        end
    end

    // The front end registers each transaction, picks the mass hypothesis and
    // takes the momentum magnitudes, then hands the pair to the queue.
    vpimt_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .first_code    (first_code),
        .second_code   (second_code),
        .first_px      (first_px),
        .first_py      (first_py),
        .first_pz      (first_pz),
        .second_px     (second_px),
        .second_py     (second_py),
        .second_pz     (second_pz),
        .electron_mass (electron_mass_reg),
        .pion_mass     (pion_mass_reg),
        .proton_mass   (proton_mass_reg),
        .fifo_full     (fifo_full),
        .push          (push),
        .push_entry    (push_entry)
    );

    // A short queue decouples the front end from the arithmetic back end.
    vpimt_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (1'b1),
        .full       (fifo_full),
        .empty      (fifo_empty),
        .head       (head)
    );

    // The back end computes both track energies, the squared pair mass and its
    // root; it takes one pair every cycle.
    vpimt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!fifo_empty),
        .in_entry (head),
        .done     (done),
        .result   (result)
    );

    assign tag = result.tag;
    assign pair_mass_kev = result.mass;
    assign mass_valid = result.ok;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !fifo_full)
        else $error("queue written while full");

    a_valid_has_tag: assert property (@(posedge clk) disable iff (!rst_n)
        done && mass_valid |-> tag != vpimt_pkg::TAG_NONE)
        else $error("valid mass without a tag");

    a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !mass_valid |-> pair_mass_kev == '0 && tag == vpimt_pkg::TAG_NONE)
        else $error("rejected pair carries a mass or a tag");
`endif

endmodule

[design/vpimt_front.sv]
`timescale 1ns / 1ps

module vpimt_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [vpimt_pkg::CODE_W-1:0] first_code,
    input  logic signed [vpimt_pkg::CODE_W-1:0] second_code,
    input  logic signed [vpimt_pkg::MOM_W-1:0]  first_px,
    input  logic signed [vpimt_pkg::MOM_W-1:0]  first_py,
    input  logic signed [vpimt_pkg::MOM_W-1:0]  first_pz,
    input  logic signed [vpimt_pkg::MOM_W-1:0]  second_px,
    input  logic signed [vpimt_pkg::MOM_W-1:0]  second_py,
    input  logic signed [vpimt_pkg::MOM_W-1:0]  second_pz,
    input  logic [vpimt_pkg::MASS_W-1:0]        electron_mass,
    input  logic [vpimt_pkg::MASS_W-1:0]        pion_mass,
    input  logic [vpimt_pkg::MASS_W-1:0]        proton_mass,
    input  logic                                fifo_full,
    output logic                                push,
    output vpimt_pkg::entry_t                   push_entry
);

    logic                       valid_reg;
    logic                       valid_next;
    vpimt_pkg::entry_t          entry_reg;
    vpimt_pkg::entry_t          entry_next;
    logic                       accept;
    logic                       e1, e2, pi1, pi2, pr1, pr2;
    logic [2:0][vpimt_pkg::MOM_W-1:0] p1;
    logic [2:0][vpimt_pkg::MOM_W-1:0] p2;

    assign p1 = {first_pz, first_py, first_px};
    assign p2 = {second_pz, second_py, second_px};

    assign push = valid_reg && !fifo_full;
    assign busy = valid_reg && fifo_full;
    assign accept = start && !busy;
    assign push_entry = entry_reg;

    // A code matches when its magnitude does; the most negative code matches nothing.
    assign e1 = (first_code == vpimt_pkg::CODE_ELECTRON) ||
                (first_code == -vpimt_pkg::CODE_ELECTRON);
    assign e2 = (second_code == vpimt_pkg::CODE_ELECTRON) ||
                (second_code == -vpimt_pkg::CODE_ELECTRON);
    assign pi1 = (first_code == vpimt_pkg::CODE_PION) ||
                 (first_code == -vpimt_pkg::CODE_PION);
    assign pi2 = (second_code == vpimt_pkg::CODE_PION) ||
                 (second_code == -vpimt_pkg::CODE_PION);
    assign pr1 = (first_code == vpimt_pkg::CODE_PROTON) ||
                 (first_code == -vpimt_pkg::CODE_PROTON);
    assign pr2 = (second_code == vpimt_pkg::CODE_PROTON) ||
                 (second_code == -vpimt_pkg::CODE_PROTON);

    always_comb
    begin
        logic [vpimt_pkg::SUM_MAG_W-1:0] s;
        entry_next = entry_reg;
        entry_next.hyp = 1'b1;
        entry_next.tag = vpimt_pkg::TAG_NONE;
        entry_next.m1 = '0;
        entry_next.m2 = '0;
        priority if (e1 && e2)
        begin
            entry_next.m1 = electron_mass;
            entry_next.m2 = electron_mass;
            entry_next.tag = vpimt_pkg::TAG_PHOTON;
        end
        else if (pi1 && pi2)
        begin
            entry_next.m1 = pion_mass;
            entry_next.m2 = pion_mass;
            entry_next.tag = vpimt_pkg::TAG_KSHORT;
        end
        else if (pr1 && pi2)
        begin
            entry_next.m1 = proton_mass;
            entry_next.m2 = pion_mass;
            entry_next.tag = first_code[vpimt_pkg::CODE_W-1] ?
                             vpimt_pkg::TAG_ANTILAMBDA : vpimt_pkg::TAG_LAMBDA;
        end
        else if (pi1 && pr2)
        begin
            entry_next.m1 = pion_mass;
            entry_next.m2 = proton_mass;
            entry_next.tag = second_code[vpimt_pkg::CODE_W-1] ?
                             vpimt_pkg::TAG_ANTILAMBDA : vpimt_pkg::TAG_LAMBDA;
        end
        else
        begin
            entry_next.hyp = 1'b0;
        end
        for (int i = 0; i < 3; i++)
        begin
            entry_next.mag1[i] = p1[i][vpimt_pkg::MOM_W-1] ? (~p1[i] + 1'b1) : p1[i];
            entry_next.mag2[i] = p2[i][vpimt_pkg::MOM_W-1] ? (~p2[i] + 1'b1) : p2[i];
            s = {p1[i][vpimt_pkg::MOM_W-1], p1[i]} + {p2[i][vpimt_pkg::MOM_W-1], p2[i]};
            entry_next.msum[i] = s[vpimt_pkg::SUM_MAG_W-1] ? (~s + 1'b1) : s;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

[design/vpimt_fifo.sv]
`timescale 1ns / 1ps

module vpimt_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  vpimt_pkg::entry_t push_entry,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output vpimt_pkg::entry_t head
);

    vpimt_pkg::entry_t mem_reg [vpimt_pkg::FIFO_DEPTH];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              do_pop;

    assign full = (count_reg == 2'(vpimt_pkg::FIFO_DEPTH));
    assign empty = (count_reg == 2'd0);
    assign head = mem_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[design/vpimt_sqrt.sv]
`timescale 1ns / 1ps

// Pipelined floor square root, one result bit per stage.
module vpimt_sqrt (
    input  logic                          clk,
    input  logic [vpimt_pkg::WIDE_W-1:0]  radicand,
    output logic [vpimt_pkg::ROOT_W-1:0]  root
);

    logic [vpimt_pkg::WIDE_W-1:0] x_reg   [vpimt_pkg::SQRT_STEPS];
    logic [vpimt_pkg::ROOT_W:0]   rem_reg [vpimt_pkg::SQRT_STEPS];
    logic [vpimt_pkg::ROOT_W-1:0] q_reg   [vpimt_pkg::SQRT_STEPS];

    for (genvar k = 0; k < vpimt_pkg::SQRT_STEPS; k++)
    begin : g_step
        logic [vpimt_pkg::WIDE_W-1:0] x_in;
        logic [vpimt_pkg::ROOT_W:0]   rem_in;
        logic [vpimt_pkg::ROOT_W-1:0] q_in;
        logic [vpimt_pkg::ROOT_W+2:0] rem_sh;
        logic [vpimt_pkg::ROOT_W+2:0] trial;
        logic [vpimt_pkg::ROOT_W+2:0] diff;
        logic                         fits;
        logic [vpimt_pkg::WIDE_W-1:0] x_next;
        logic [vpimt_pkg::ROOT_W:0]   rem_next;
        logic [vpimt_pkg::ROOT_W-1:0] q_next;

        if (k == 0)
        begin : g_first
            assign x_in = radicand;
            assign rem_in = '0;
            assign q_in = '0;
        end
        else
        begin : g_rest
            assign x_in = x_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign q_in = q_reg[k-1];
        end

        assign rem_sh = {rem_in, x_in[vpimt_pkg::WIDE_W-1 -: 2]};
        assign trial = {1'b0, q_in, 2'b01};
        assign diff = rem_sh - trial;
        assign fits = (rem_sh >= trial);
        assign x_next = {x_in[vpimt_pkg::WIDE_W-3:0], 2'b00};
        assign rem_next = fits ? diff[vpimt_pkg::ROOT_W:0] : rem_sh[vpimt_pkg::ROOT_W:0];
        assign q_next = {q_in[vpimt_pkg::ROOT_W-2:0], fits};

        always_ff @(posedge clk)
        begin
            x_reg[k] <= x_next;
            rem_reg[k] <= rem_next;
            q_reg[k] <= q_next;
        end
    end

    assign root = q_reg[vpimt_pkg::SQRT_STEPS-1];

endmodule

[design/vpimt_back.sv]
`timescale 1ns / 1ps

module vpimt_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  vpimt_pkg::entry_t  in_entry,
    output logic               done,
    output vpimt_pkg::result_t result
);

    localparam int N = vpimt_pkg::SQRT_STEPS;

    // Squares stage.
    logic                                 s1_valid_reg;
    logic                                 s1_hyp_reg;
    logic [vpimt_pkg::TAG_W-1:0]          s1_tag_reg;
    logic [2:0][2*vpimt_pkg::MAG_W-1:0]   s1_sq1_reg;
    logic [2:0][2*vpimt_pkg::MAG_W-1:0]   s1_sq2_reg;
    logic [2:0][vpimt_pkg::WIDE_W-1:0]    s1_sqs_reg;
    logic [2*vpimt_pkg::MASS_W-1:0]       s1_m1sq_reg;
    logic [2*vpimt_pkg::MASS_W-1:0]       s1_m2sq_reg;

    // Sums stage.
    logic                                 s2_valid_reg;
    logic                                 s2_hyp_reg;
    logic [vpimt_pkg::TAG_W-1:0]          s2_tag_reg;
    logic [vpimt_pkg::WIDE_W-1:0]         s2_pp1_reg;
    logic [vpimt_pkg::WIDE_W-1:0]         s2_pp2_reg;
    logic [vpimt_pkg::WIDE_W-1:0]         s2_pt_reg;

    // Side band that travels along the energy roots.
    logic                                 d1_valid_reg [N];
    logic                                 d1_hyp_reg   [N];
    logic [vpimt_pkg::TAG_W-1:0]          d1_tag_reg   [N];
    logic [vpimt_pkg::WIDE_W-1:0]         d1_pt_reg    [N];

    logic [vpimt_pkg::ROOT_W-1:0]         e1_root, e2_root;

    logic                                 s3_valid_reg, s3_hyp_reg;
    logic [vpimt_pkg::TAG_W-1:0]          s3_tag_reg;
    logic [vpimt_pkg::WIDE_W-1:0]         s3_pt_reg;
    logic [vpimt_pkg::ROOT_W-1:0]         s3_es_reg;

    logic                                 s4_valid_reg, s4_hyp_reg;
    logic [vpimt_pkg::TAG_W-1:0]          s4_tag_reg;
    logic [vpimt_pkg::WIDE_W-1:0]         s4_pt_reg;
    logic [vpimt_pkg::WIDE_W-1:0]         s4_s_reg;

    logic                                 s5_valid_reg, s5_ok_reg;
    logic [vpimt_pkg::TAG_W-1:0]          s5_tag_reg;
    logic [vpimt_pkg::WIDE_W-1:0]         s5_diff_reg;

    logic                                 d2_valid_reg [N];
    logic                                 d2_ok_reg    [N];
    logic [vpimt_pkg::TAG_W-1:0]          d2_tag_reg   [N];

    logic [vpimt_pkg::ROOT_W-1:0]         mass_root;

    logic                                 out_valid_reg;
    vpimt_pkg::result_t                   out_reg;
    vpimt_pkg::result_t                   out_next;

    // Control pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < N; i++)
            begin
                d1_valid_reg[i] <= 1'b0;
                d2_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            d1_valid_reg[0] <= s2_valid_reg;
            for (int i = 1; i < N; i++)
            begin
                d1_valid_reg[i] <= d1_valid_reg[i-1];
                d2_valid_reg[i] <= d2_valid_reg[i-1];
            end
            s3_valid_reg <= d1_valid_reg[N-1];
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            d2_valid_reg[0] <= s5_valid_reg;
            out_valid_reg <= d2_valid_reg[N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        s1_hyp_reg <= in_entry.hyp;
        s1_tag_reg <= in_entry.tag;
        for (int i = 0; i < 3; i++)
        begin
            s1_sq1_reg[i] <= in_entry.mag1[i] * in_entry.mag1[i];
            s1_sq2_reg[i] <= in_entry.mag2[i] * in_entry.mag2[i];
            s1_sqs_reg[i] <= in_entry.msum[i] * in_entry.msum[i];
        end
        s1_m1sq_reg <= in_entry.m1 * in_entry.m1;
        s1_m2sq_reg <= in_entry.m2 * in_entry.m2;

        s2_hyp_reg <= s1_hyp_reg;
        s2_tag_reg <= s1_tag_reg;
        s2_pp1_reg <= 64'(s1_sq1_reg[0]) + 64'(s1_sq1_reg[1]) + 64'(s1_sq1_reg[2])
                      + 64'(s1_m1sq_reg);
        s2_pp2_reg <= 64'(s1_sq2_reg[0]) + 64'(s1_sq2_reg[1]) + 64'(s1_sq2_reg[2])
                      + 64'(s1_m2sq_reg);
        s2_pt_reg <= s1_sqs_reg[0] + s1_sqs_reg[1] + s1_sqs_reg[2];

        d1_hyp_reg[0] <= s2_hyp_reg;
        d1_tag_reg[0] <= s2_tag_reg;
        d1_pt_reg[0] <= s2_pt_reg;
        for (int i = 1; i < N; i++)
        begin
            d1_hyp_reg[i] <= d1_hyp_reg[i-1];
            d1_tag_reg[i] <= d1_tag_reg[i-1];
            d1_pt_reg[i] <= d1_pt_reg[i-1];
            d2_ok_reg[i] <= d2_ok_reg[i-1];
            d2_tag_reg[i] <= d2_tag_reg[i-1];
        end

        // Energies stay below 2^31, so their sum fits the root width.
        s3_hyp_reg <= d1_hyp_reg[N-1];
        s3_tag_reg <= d1_tag_reg[N-1];
        s3_pt_reg <= d1_pt_reg[N-1];
        s3_es_reg <= e1_root + e2_root;

        s4_hyp_reg <= s3_hyp_reg;
        s4_tag_reg <= s3_tag_reg;
        s4_pt_reg <= s3_pt_reg;
        s4_s_reg <= s3_es_reg * s3_es_reg;

        s5_ok_reg <= s4_hyp_reg && (s4_s_reg > s4_pt_reg);
        s5_tag_reg <= s4_tag_reg;
        s5_diff_reg <= s4_s_reg - s4_pt_reg;

        d2_ok_reg[0] <= s5_ok_reg;
        d2_tag_reg[0] <= s5_tag_reg;

        out_reg <= out_next;
    end

    vpimt_sqrt u_sqrt_e1 (
        .clk      (clk),
        .radicand (s2_pp1_reg),
        .root     (e1_root)
    );

    vpimt_sqrt u_sqrt_e2 (
        .clk      (clk),
        .radicand (s2_pp2_reg),
        .root     (e2_root)
    );

    vpimt_sqrt u_sqrt_mass (
        .clk      (clk),
        .radicand (s5_diff_reg),
        .root     (mass_root)
    );

    always_comb
    begin
        out_next.ok = d2_ok_reg[N-1];
        out_next.tag = d2_ok_reg[N-1] ? d2_tag_reg[N-1] : vpimt_pkg::TAG_NONE;
        out_next.mass = d2_ok_reg[N-1] ? mass_root : '0;
    end

    assign done = out_valid_reg;
    assign result = out_reg;

endmodule
